### src/icosphere_triangle_subdivider_assert.svh
// Assertion macros for the icosphere triangle subdivider.
`ifndef ICOSPHERE_TRIANGLE_SUBDIVIDER_ASSERT_SVH
`define ICOSPHERE_TRIANGLE_SUBDIVIDER_ASSERT_SVH
`ifndef SYNTH
// The consequent holds in the same cycle as the antecedent.
`define ITSUB_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// The consequent holds in the cycle after the antecedent.
`define ITSUB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ITSUB_ASSERT_SAME(label, ante, cons)
`define ITSUB_ASSERT_NEXT(label, ante, cons)
`endif
`endif

### src/itsub_pkg.sv
package itsub_pkg;

    localparam int FRAC_BITS  = 14;
    localparam int MAX_DEPTH  = 3;
    localparam int NUM_FACES  = 20;
    localparam int ADDR_W     = 5;
    localparam int COUNT_W    = 7;

    // Table constants X and Z reduced to Q1.14.
    localparam logic signed [15:0] X_VAL = 16'sd8614;
    localparam logic signed [15:0] Z_VAL = 16'sd13937;

    // Component codes of the twelve icosahedron vertices.
    localparam logic [2:0] C_ZERO = 3'd0;
    localparam logic [2:0] C_PX   = 3'd1;
    localparam logic [2:0] C_NX   = 3'd2;
    localparam logic [2:0] C_PZ   = 3'd3;
    localparam logic [2:0] C_NZ   = 3'd4;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } vec3_t;

    // A face waiting in the queue between front and back.
    typedef struct packed {
        logic       valid;
        logic [4:0] face;
    } itsub_job_t;

    localparam logic [2:0] VERT_CODE [12][3] = '{
        '{C_NX, C_ZERO, C_PZ}, '{C_PX, C_ZERO, C_PZ}, '{C_NX, C_ZERO, C_NZ},
        '{C_PX, C_ZERO, C_NZ}, '{C_ZERO, C_PZ, C_PX}, '{C_ZERO, C_PZ, C_NX},
        '{C_ZERO, C_NZ, C_PX}, '{C_ZERO, C_NZ, C_NX}, '{C_PZ, C_PX, C_ZERO},
        '{C_NZ, C_PX, C_ZERO}, '{C_PZ, C_NX, C_ZERO}, '{C_NZ, C_NX, C_ZERO}
    };

    localparam logic [3:0] FACE_CORNERS [20][3] = '{
        '{4'd0, 4'd4, 4'd1},  '{4'd0, 4'd9, 4'd4},  '{4'd9, 4'd5, 4'd4},
        '{4'd4, 4'd5, 4'd8},  '{4'd4, 4'd8, 4'd1},  '{4'd8, 4'd10, 4'd1},
        '{4'd8, 4'd3, 4'd10}, '{4'd5, 4'd3, 4'd8},  '{4'd5, 4'd2, 4'd3},
        '{4'd2, 4'd7, 4'd3},  '{4'd7, 4'd10, 4'd3}, '{4'd7, 4'd6, 4'd10},
        '{4'd7, 4'd11, 4'd6}, '{4'd11, 4'd0, 4'd6}, '{4'd0, 4'd1, 4'd6},
        '{4'd6, 4'd1, 4'd10}, '{4'd9, 4'd0, 4'd11}, '{4'd9, 4'd11, 4'd2},
        '{4'd9, 4'd2, 4'd5},  '{4'd7, 4'd2, 4'd11}
    };

    function automatic logic signed [15:0] code_value(input logic [2:0] code);
        case (code)
            C_PX:    code_value = X_VAL;
            C_NX:    code_value = -X_VAL;
            C_PZ:    code_value = Z_VAL;
            C_NZ:    code_value = -Z_VAL;
            default: code_value = 16'sd0;
        endcase
    endfunction

    // Corner number corner (0..2) of face face (0..19).
    function automatic vec3_t corner_vec(input logic [4:0] face, input logic [1:0] corner);
        logic [3:0] v;
        vec3_t r;
        v = FACE_CORNERS[face][corner];
        r.x = code_value(VERT_CODE[v][0]);
        r.y = code_value(VERT_CODE[v][1]);
        r.z = code_value(VERT_CODE[v][2]);
        corner_vec = r;
    endfunction

endpackage

### src/itsub_if.sv
interface itsub_face_if;
    import itsub_pkg::*;
    logic       valid;
    logic       ready;
    logic [4:0] face_index;
    modport source (output valid, output face_index, input ready);
    modport sink (input valid, input face_index, output ready);
endinterface

interface itsub_tri_if;
    import itsub_pkg::*;
    logic              valid;
    logic              ready;
    logic signed [15:0] ax, ay, az, bx, by_coord, bz, cx, cy, cz;
    logic              last_of_face;
    modport source (output valid, output ax, output ay, output az, output bx,
                    output by_coord, output bz, output cx, output cy, output cz,
                    output last_of_face, input ready);
    modport sink (input valid, input ax, input ay, input az, input bx,
                  input by_coord, input bz, input cx, input cy, input cz,
                  input last_of_face, output ready);
endinterface

### src/itsub_front.sv
module itsub_front
    import itsub_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    itsub_face_if.sink   faces,
    input  logic         pop,
    output itsub_job_t   job
);

    logic [4:0] slot_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;

    // Faces outside the table are taken and dropped.
    assign faces.ready = (count_reg != 2'd2);
    assign push = faces.valid && faces.ready && (faces.face_index < 5'(NUM_FACES));

    assign job.valid = (count_reg != 2'd0);
    assign job.face  = slot_reg[rd_ptr_reg];

    // Two-entry queue toward the back end.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                slot_reg[wr_ptr_reg] <= faces.face_index;
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

### src/itsub_norm.sv
module itsub_norm
    import itsub_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  vec3_t a,
    input  vec3_t b,
    output logic  done,
    output vec3_t res
);

    typedef enum logic [2:0] {N_IDLE, N_SUM, N_SQ, N_SQRT, N_DINIT, N_DSTEP} nstate_t;

    nstate_t            state_reg;
    logic signed [16:0] s_reg [3];
    logic [15:0]        m_reg [3];
    logic [31:0]        prod_reg, n_reg, r_reg, bit_reg;
    logic [1:0]         idx_reg;
    logic [3:0]         step_reg;
    logic [15:0]        d_reg, rem_reg;
    logic [14:0]        lo_reg, q_reg;
    logic               done_reg;
    vec3_t              res_reg;

    logic [32:0] trial;
    logic [29:0] num;
    logic [16:0] shifted;
    logic [15:0] mcur;
    logic [14:0] qnew;
    logic [15:0] signed_q;

    assign done = done_reg;
    assign res  = res_reg;

    // Square root trial and division step datapath.
    always_comb
    begin
        trial   = {1'b0, r_reg} + {1'b0, bit_reg};
        mcur    = m_reg[idx_reg];
        num     = {mcur, 14'b0} + 30'(d_reg >> 1);
        shifted = {rem_reg, lo_reg[14]};
        qnew    = {q_reg[13:0], (shifted >= {1'b0, d_reg})};
        signed_q = s_reg[idx_reg][16] ? -{1'b0, qnew} : {1'b0, qnew};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= N_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                N_IDLE:
                begin
                    if (start)
                    begin
                        s_reg[0] <= 17'(a.x) + 17'(b.x);
                        s_reg[1] <= 17'(a.y) + 17'(b.y);
                        s_reg[2] <= 17'(a.z) + 17'(b.z);
                        state_reg <= N_SUM;
                    end
                end
                N_SUM:
                begin
                    // Magnitudes of the summed components.
                    for (int j = 0; j < 3; j++)
                    begin
                        m_reg[j] <= s_reg[j][16] ? 16'(-s_reg[j]) : 16'(s_reg[j]);
                    end
                    prod_reg  <= 32'd0;
                    n_reg     <= 32'd0;
                    idx_reg   <= 2'd0;
                    state_reg <= N_SQ;
                end
                N_SQ:
                begin
                    // One square per cycle, each accumulated in the following cycle.
                    prod_reg <= (idx_reg == 2'd3) ? 32'd0 : mcur * mcur;
                    n_reg    <= n_reg + prod_reg;
                    idx_reg  <= idx_reg + 2'd1;
                    if (idx_reg == 2'd3)
                    begin
                        r_reg     <= 32'd0;
                        bit_reg   <= 32'h4000_0000;
                        step_reg  <= 4'd0;
                        state_reg <= N_SQRT;
                    end
                end
                N_SQRT:
                begin
                    // Bit by bit integer square root, two radicand bits a cycle.
                    if ({1'b0, n_reg} >= trial)
                    begin
                        n_reg <= n_reg - trial[31:0];
                        r_reg <= (r_reg >> 1) + bit_reg;
                    end
                    else
                    begin
                        r_reg <= r_reg >> 1;
                    end
                    bit_reg  <= bit_reg >> 2;
                    step_reg <= step_reg + 4'd1;
                    if (step_reg == 4'd15)
                    begin
                        idx_reg <= 2'd0;
                        if ({1'b0, n_reg} >= trial)
                        begin
                            d_reg <= 16'((r_reg >> 1) + bit_reg);
                        end
                        else
                        begin
                            d_reg <= 16'(r_reg >> 1);
                        end
                        state_reg <= N_DINIT;
                    end
                end
                N_DINIT:
                begin
                    if (d_reg == 16'd0)
                    begin
                        // Zero-length sum is passed through unchanged.
                        res_reg.x <= 16'(s_reg[0]);
                        res_reg.y <= 16'(s_reg[1]);
                        res_reg.z <= 16'(s_reg[2]);
                        done_reg  <= 1'b1;
                        state_reg <= N_IDLE;
                    end
                    else
                    begin
                        // The upper quotient bits are known zero.
                        rem_reg   <= {1'b0, num[29:15]};
                        lo_reg    <= num[14:0];
                        q_reg     <= 15'd0;
                        step_reg  <= 4'd0;
                        state_reg <= N_DSTEP;
                    end
                end
                N_DSTEP:
                begin
                    // Restoring division, one quotient bit a cycle.
                    if (shifted >= {1'b0, d_reg})
                    begin
                        rem_reg <= 16'(shifted - {1'b0, d_reg});
                    end
                    else
                    begin
                        rem_reg <= shifted[15:0];
                    end
                    lo_reg   <= {lo_reg[13:0], 1'b0};
                    q_reg    <= qnew;
                    step_reg <= step_reg + 4'd1;
                    if (step_reg == 4'd14)
                    begin
                        case (idx_reg)
                            2'd0:    res_reg.x <= signed_q;
                            2'd1:    res_reg.y <= signed_q;
                            default: res_reg.z <= signed_q;
                        endcase
                        if (idx_reg == 2'd2)
                        begin
                            done_reg  <= 1'b1;
                            state_reg <= N_IDLE;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + 2'd1;
                            state_reg <= N_DINIT;
                        end
                    end
                end
                default: state_reg <= N_IDLE;
            endcase
        end
    end

endmodule

### src/itsub_back.sv
module itsub_back
    import itsub_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [1:0]  depth,
    input  itsub_job_t  job,
    output logic        pop,
    itsub_tri_if.source tris
);

    typedef enum logic [3:0] {
        B_IDLE, B_LOAD, B_DESC, B_RDA, B_RDB, B_RDW, B_NORM, B_COPY, B_CPWR,
        B_EMIT, B_GRAB, B_PUSH, B_ASC
    } bstate_t;

    bstate_t          state_reg;
    vec3_t            mem [24];
    vec3_t            rd_data_reg;
    logic [4:0]       face_reg;
    logic [1:0]       lvl_reg, cl_reg, i_reg, k_reg;
    logic [1:0]       cp_reg [3];
    logic [COUNT_W-1:0] cnt_reg;
    vec3_t            opa_reg, opb_reg;
    vec3_t            tri_reg [3];
    logic             ov_reg, last_reg, start_reg;
    vec3_t            oa_reg, ob_reg, oc_reg;

    logic [ADDR_W-1:0] rd_addr, wr_addr, lvl_base, cl_base;
    logic              wr_en;
    vec3_t             wr_data, norm_res;
    logic              norm_done;
    logic              load_out;
    logic [COUNT_W-1:0] total;

    itsub_norm u_norm (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start_reg),
        .a     (opa_reg),
        .b     (opb_reg),
        .done  (norm_done),
        .res   (norm_res)
    );

    // Slot 0..5 of level that is picked as corner i of child k.
    function automatic logic [2:0] pick_slot(input logic [1:0] k, input logic [1:0] i);
        logic [2:0] s;
        case ({k, i})
            4'b00_00: s = 3'd0;
            4'b00_01: s = 3'd3;
            4'b00_10: s = 3'd5;
            4'b01_00: s = 3'd1;
            4'b01_01: s = 3'd4;
            4'b01_10: s = 3'd3;
            4'b10_00: s = 3'd2;
            4'b10_01: s = 3'd5;
            4'b10_10: s = 3'd4;
            4'b11_00: s = 3'd3;
            4'b11_01: s = 3'd4;
            default:  s = 3'd5;
        endcase
        pick_slot = s;
    endfunction

    always_comb
    begin
        lvl_base = (ADDR_W'(lvl_reg) << 2) + (ADDR_W'(lvl_reg) << 1);
        cl_base  = (ADDR_W'(cl_reg) << 2) + (ADDR_W'(cl_reg) << 1);
        total    = COUNT_W'(1) << {depth, 1'b0};
        load_out = (state_reg == B_PUSH) && (!ov_reg || tris.ready);
        rd_addr  = lvl_base + ADDR_W'(i_reg);
        wr_addr  = ADDR_W'(i_reg);
        wr_data  = corner_vec(face_reg, i_reg);
        wr_en    = 1'b0;
        case (state_reg)
            B_LOAD:
            begin
                wr_en = 1'b1;
            end
            B_RDA:
            begin
                rd_addr = lvl_base + ADDR_W'(k_reg);
            end
            B_RDB:
            begin
                rd_addr = lvl_base + ((k_reg == 2'd2) ? ADDR_W'(0) : ADDR_W'(k_reg + 2'd1));
            end
            B_NORM:
            begin
                wr_en   = norm_done;
                wr_addr = lvl_base + ADDR_W'(3) + ADDR_W'(k_reg);
                wr_data = norm_res;
            end
            B_COPY:
            begin
                rd_addr = cl_base + ADDR_W'(pick_slot(cp_reg[cl_reg], i_reg));
            end
            B_CPWR:
            begin
                wr_en   = 1'b1;
                wr_addr = cl_base + ADDR_W'(6) + ADDR_W'(i_reg);
                wr_data = rd_data_reg;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    // Vertex store: three corners and three midpoints per level, registered read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign pop = (state_reg == B_IDLE) && job.valid;

    assign tris.valid        = ov_reg;
    assign tris.ax           = oa_reg.x;
    assign tris.ay           = oa_reg.y;
    assign tris.az           = oa_reg.z;
    assign tris.bx           = ob_reg.x;
    assign tris.by_coord     = ob_reg.y;
    assign tris.bz           = ob_reg.z;
    assign tris.cx           = oc_reg.x;
    assign tris.cy           = oc_reg.y;
    assign tris.cz           = oc_reg.z;
    assign tris.last_of_face = last_reg;

    // Recursion sequencer and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            ov_reg    <= 1'b0;
            start_reg <= 1'b0;
            lvl_reg   <= 2'd0;
            cp_reg    <= '{2'd0, 2'd0, 2'd0};
        end
        else
        begin
            start_reg <= 1'b0;
            if (load_out)
            begin
                ov_reg <= 1'b1;
            end
            else if (tris.ready)
            begin
                ov_reg <= 1'b0;
            end
            case (state_reg)
                B_IDLE:
                begin
                    if (job.valid)
                    begin
                        face_reg  <= job.face;
                        i_reg     <= 2'd0;
                        cnt_reg   <= '0;
                        state_reg <= B_LOAD;
                    end
                end
                B_LOAD:
                begin
                    i_reg <= i_reg + 2'd1;
                    if (i_reg == 2'd2)
                    begin
                        lvl_reg   <= 2'd0;
                        state_reg <= B_DESC;
                    end
                end
                B_DESC:
                begin
                    i_reg <= 2'd0;
                    k_reg <= 2'd0;
                    state_reg <= (lvl_reg < depth) ? B_RDA : B_EMIT;
                end
                B_RDA:
                begin
                    state_reg <= B_RDB;
                end
                B_RDB:
                begin
                    opa_reg   <= rd_data_reg;
                    state_reg <= B_RDW;
                end
                B_RDW:
                begin
                    opb_reg   <= rd_data_reg;
                    start_reg <= 1'b1;
                    state_reg <= B_NORM;
                end
                B_NORM:
                begin
                    if (norm_done)
                    begin
                        if (k_reg == 2'd2)
                        begin
                            cp_reg[lvl_reg] <= 2'd0;
                            cl_reg          <= lvl_reg;
                            i_reg           <= 2'd0;
                            state_reg       <= B_COPY;
                        end
                        else
                        begin
                            k_reg     <= k_reg + 2'd1;
                            state_reg <= B_RDA;
                        end
                    end
                end
                B_COPY:
                begin
                    state_reg <= B_CPWR;
                end
                B_CPWR:
                begin
                    i_reg <= i_reg + 2'd1;
                    if (i_reg == 2'd2)
                    begin
                        lvl_reg   <= cl_reg + 2'd1;
                        state_reg <= B_DESC;
                    end
                    else
                    begin
                        state_reg <= B_COPY;
                    end
                end
                B_EMIT:
                begin
                    state_reg <= B_GRAB;
                end
                B_GRAB:
                begin
                    tri_reg[i_reg] <= rd_data_reg;
                    i_reg <= i_reg + 2'd1;
                    if (i_reg == 2'd2)
                    begin
                        state_reg <= B_PUSH;
                    end
                    else
                    begin
                        state_reg <= B_EMIT;
                    end
                end
                B_PUSH:
                begin
                    if (load_out)
                    begin
                        oa_reg    <= tri_reg[0];
                        ob_reg    <= tri_reg[1];
                        oc_reg    <= tri_reg[2];
                        last_reg  <= ((cnt_reg + COUNT_W'(1)) == total);
                        cnt_reg   <= cnt_reg + COUNT_W'(1);
                        state_reg <= B_ASC;
                    end
                end
                B_ASC:
                begin
                    // Climb until a level still has a child to visit.
                    if (lvl_reg == 2'd0)
                    begin
                        state_reg <= B_IDLE;
                    end
                    else if (cp_reg[lvl_reg - 2'd1] < 2'd3)
                    begin
                        cp_reg[lvl_reg - 2'd1] <= cp_reg[lvl_reg - 2'd1] + 2'd1;
                        cl_reg    <= lvl_reg - 2'd1;
                        i_reg     <= 2'd0;
                        state_reg <= B_COPY;
                    end
                    else
                    begin
                        lvl_reg <= lvl_reg - 2'd1;
                    end
                end
                default: state_reg <= B_IDLE;
            endcase
        end
    end

endmodule

### src/icosphere_triangle_subdivider.sv
// Icosphere triangle subdivider.
// Channel faces carries one icosahedron face index (0..19) a beat; an index
// above 19 is taken and produces no triangles. Channel tris returns the leaf
// triangles of that face, 4^depth beats, nine Q1.14 coordinates each, with
// last_of_face set on the final beat. cfg_we/cfg_wdata write the subdivision
// depth (reset 1); write it only while the block is idle.
// A two-entry face queue parts the input side from the recursion sequencer.
// Each midpoint runs through one shared iterative unit: operand reads, a start
// strobe, a sum of the two corners, the squares of the summed components, a bit
// by bit square root and three restoring divisions. A split computes three
// midpoints and then copies the corners of its first child; each later sibling
// gets a copy of its own. Faces are worked one at a time.
// Reset clears the queue, the sequencer and the output register; the vertex
// store needs no clearing. When tris stalls, the held beat waits in the output
// register, the sequencer stops at its next triangle, and faces keeps
// accepting until the queue is full.
module icosphere_triangle_subdivider
    import itsub_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    itsub_face_if.sink  faces,
    itsub_tri_if.source tris,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_wdata
);

    `include "icosphere_triangle_subdivider_assert.svh"

    logic [1:0] depth_reg;
    itsub_job_t job;
    logic       pop;

    // Depth register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg <= 2'd1;
        end
        else if (cfg_we)
        begin
            depth_reg <= cfg_wdata;
        end
    end

    itsub_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .faces (faces),
        .pop   (pop),
        .job   (job)
    );

    itsub_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .depth (depth_reg),
        .job   (job),
        .pop   (pop),
        .tris  (tris)
    );

    // The back end takes a face only when the queue holds one.
    `ITSUB_ASSERT_SAME(a_pop_needs_job, pop, job.valid)
    // A full queue always has a face to hand over.
    `ITSUB_ASSERT_SAME(a_stall_means_queued, !faces.ready, job.valid)

endmodule

### dv/tb.sv
module tb;
    import itsub_pkg::*;

    typedef longint pvec_t [3];

    typedef struct {
        logic [15:0] c [9];
        logic        last;
    } tri_t;

    typedef struct {
        int    depth;
        int    face;
        bit    typed;
        tri_t  want_tri;
    } stim_row_t;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 100;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [1:0] cfg_wdata;

    itsub_face_if faces_if ();
    itsub_tri_if  tris_if ();

    icosphere_triangle_subdivider dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .faces     (faces_if),
        .tris      (tris_if),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    tri_t        pending_tris [$];
    int          depth_cfg;
    int          leaf_count;
    int          leaf_total;
    int          error_count;
    int          faces_sent;
    int          faces_ignored;
    int          tris_seen;
    int          idle_cycles;
    bit          sink_quiet;
    bit          source_quiet;
    int          stall_left;
    bit          depth_used [4];
    stim_row_t   rows [$];

    // Free-running clock.
    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Print one mismatch line and count it.
    task automatic report(input string what, input int got, input int want);
        error_count++;
        $display("mismatch: %s got %0d expected %0d", what, got, want);
    endtask

    // Q1.14 value of one component code.
    function automatic longint coord_of(input logic [2:0] code);
        case (code)
            C_PX:    return longint'(X_VAL);
            C_NX:    return -longint'(X_VAL);
            C_PZ:    return longint'(Z_VAL);
            C_NZ:    return -longint'(Z_VAL);
            default: return 0;
        endcase
    endfunction

    // Floor of the square root, bit by bit.
    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Edge midpoint pushed back onto the unit sphere; a zero sum stays zero.
    function automatic pvec_t unit_mid(input pvec_t a, input pvec_t b);
        pvec_t s;
        pvec_t o;
        longint unsigned m [3];
        longint unsigned n;
        longint unsigned d;
        longint unsigned q;
        n = 0;
        for (int i = 0; i < 3; i++)
        begin
            s[i] = a[i] + b[i];
            m[i] = (s[i] < 0) ? -s[i] : s[i];
            n = n + m[i] * m[i];
        end
        d = int_sqrt(n);
        if (d == 0) return s;
        for (int i = 0; i < 3; i++)
        begin
            q = ((m[i] << FRAC_BITS) + d / 2) / d;
            o[i] = (s[i] < 0) ? -longint'(q) : longint'(q);
        end
        return o;
    endfunction

    // Walk the split tree depth first and queue each leaf triangle.
    task automatic emit_leaves(input pvec_t a, input pvec_t b, input pvec_t c, input int lvl);
        pvec_t m12;
        pvec_t m23;
        pvec_t m31;
        tri_t  t;
        if (lvl == 0)
        begin
            for (int i = 0; i < 3; i++)
            begin
                t.c[i]     = a[i][15:0];
                t.c[3 + i] = b[i][15:0];
                t.c[6 + i] = c[i][15:0];
            end
            leaf_count++;
            t.last = (leaf_count == leaf_total);
            pending_tris.push_back(t);
        end
        else
        begin
            m12 = unit_mid(a, b);
            m23 = unit_mid(b, c);
            m31 = unit_mid(c, a);
            emit_leaves(a, m12, m31, lvl - 1);
            emit_leaves(b, m23, m12, lvl - 1);
            emit_leaves(c, m31, m23, lvl - 1);
            emit_leaves(m12, m23, m31, lvl - 1);
        end
    endtask

    // Expected triangles of one face at the current depth.
    task automatic predict_face_tris(input int face);
        pvec_t v [3];
        int    corner;
        if (face >= NUM_FACES)
        begin
            faces_ignored++;
            return;
        end
        for (int i = 0; i < 3; i++)
        begin
            corner = FACE_CORNERS[face][i];
            for (int j = 0; j < 3; j++) v[i][j] = coord_of(VERT_CODE[corner][j]);
        end
        leaf_count = 0;
        leaf_total = 1 << (2 * depth_cfg);
        depth_used[depth_cfg] = 1'b1;
        emit_leaves(v[0], v[1], v[2], depth_cfg);
    endtask

    // Random gap: mostly short, a few long.
    function automatic int gap_len();
        if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Send one face beat and wait for it to be taken.
    task automatic send_face(input int face, input bit typed, input tri_t want_tri);
        int gap;
        gap = source_quiet ? 0 : (($urandom_range(0, 2) == 0) ? gap_len() : 0);
        if (gap > 0)
        begin
            faces_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        faces_if.valid      <= 1'b1;
        faces_if.face_index <= face[4:0];
        @(posedge clk);
        while (!faces_if.ready) @(posedge clk);
        faces_sent++;
        if (typed)
        begin
            pending_tris.push_back(want_tri);
            depth_used[depth_cfg] = 1'b1;
        end
        else
        begin
            predict_face_tris(face);
        end
    endtask

    // Wait for every expected triangle, then let the block settle.
    task automatic drain();
        faces_if.valid <= 1'b0;
        while (pending_tris.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write the depth register while the block is idle.
    task automatic set_depth(input int d);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= d[1:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
        depth_cfg = d;
    endtask

    // Build one stimulus row.
    function automatic stim_row_t row(input int d, input int f, input bit typed,
                                      input logic signed [15:0] k [9], input bit last);
        stim_row_t r;
        r.depth = d;
        r.face  = f;
        r.typed = typed;
        for (int i = 0; i < 9; i++) r.want_tri.c[i] = k[i];
        r.want_tri.last = last;
        return r;
    endfunction

    // Result sink with random stalls.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            tris_if.ready <= 1'b0;
            stall_left    <= 0;
        end
        else if (stall_left > 0)
        begin
            tris_if.ready <= 1'b0;
            stall_left    <= stall_left - 1;
        end
        else
        begin
            tris_if.ready <= 1'b1;
            if (!sink_quiet && $urandom_range(0, 5) == 0) stall_left <= gap_len();
        end
    end

    // Compare each triangle beat with the oldest expectation.
    always @(posedge clk)
    begin
        tri_t want;
        logic [15:0] got [9];
        if (rst_n && tris_if.valid && tris_if.ready)
        begin
            got = '{tris_if.ax, tris_if.ay, tris_if.az, tris_if.bx, tris_if.by_coord,
                    tris_if.bz, tris_if.cx, tris_if.cy, tris_if.cz};
            tris_seen++;
            if (pending_tris.size() == 0)
            begin
                report("unexpected triangle beat", 1, 0);
            end
            else
            begin
                want = pending_tris.pop_front();
                for (int i = 0; i < 9; i++)
                    if (got[i] !== want.c[i])
                        report($sformatf("triangle %0d coordinate %0d", tris_seen, i),
                               $signed(got[i]), $signed(want.c[i]));
                if (tris_if.last_of_face !== want.last)
                    report($sformatf("triangle %0d last_of_face", tris_seen),
                           tris_if.last_of_face, want.last);
            end
        end
    end

    // Watchdog on cycles with no beat on either channel.
    always @(posedge clk)
    begin
        if ((faces_if.valid && faces_if.ready) || (tris_if.valid && tris_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout after %0d idle cycles", idle_cycles);
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        logic signed [15:0] none [9];
        logic signed [15:0] face0 [9];
        logic signed [15:0] face19 [9];
        int phase_depth [6];
        int phase_items [6];
        int f;
        int sent_items;
        none   = '{default: 16'sd0};
        face0  = '{-16'sd8614, 16'sd0, 16'sd13937, 16'sd0, 16'sd13937, 16'sd8614,
                   16'sd8614, 16'sd0, 16'sd13937};
        face19 = '{16'sd0, -16'sd13937, -16'sd8614, -16'sd8614, 16'sd0, -16'sd13937,
                   -16'sd13937, -16'sd8614, 16'sd0};
        error_count   = 0;
        faces_sent    = 0;
        faces_ignored = 0;
        tris_seen     = 0;
        sink_quiet    = 1'b0;
        source_quiet  = 1'b0;
        depth_cfg     = 1;
        rst_n               <= 1'b0;
        cfg_we              <= 1'b0;
        cfg_wdata           <= 2'd0;
        faces_if.valid      <= 1'b0;
        faces_if.face_index <= 5'd0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows: reset depth, field extremes, ignored indexes, all depths.
        rows.push_back(row(1, 0, 0, none, 0));
        rows.push_back(row(1, 19, 0, none, 0));
        rows.push_back(row(1, 20, 0, none, 0));
        rows.push_back(row(1, 31, 0, none, 0));
        rows.push_back(row(1, 7, 0, none, 0));
        rows.push_back(row(0, 0, 1, face0, 1));
        rows.push_back(row(0, 19, 1, face19, 1));
        rows.push_back(row(0, 31, 0, none, 0));
        rows.push_back(row(0, 10, 0, none, 0));
        rows.push_back(row(3, 3, 0, none, 0));
        rows.push_back(row(3, 21, 0, none, 0));
        rows.push_back(row(2, 12, 0, none, 0));
        rows.push_back(row(2, 25, 0, none, 0));
        rows.push_back(row(2, 18, 0, none, 0));
        foreach (rows[i])
        begin
            if (rows[i].depth != depth_cfg) set_depth(rows[i].depth);
            send_face(rows[i].face, rows[i].typed, rows[i].want_tri);
        end

        // Random phases over several depths; most faces go to the cheaper depths.
        phase_depth = '{0, 1, 2, 3, 1, 0};
        phase_items = '{86, 86, 48, 8, 28, 10};
        foreach (phase_depth[p])
        begin
            set_depth(phase_depth[p]);
            sink_quiet   = (p == 4);
            source_quiet = (p == 5);
            sent_items   = 0;
            while (sent_items < phase_items[p])
            begin
                f = ($urandom_range(0, 6) == 0) ? $urandom_range(20, 31)
                                                : $urandom_range(0, 19);
                sent_items++;
                send_face(f, 1'b0, '{default: 0});
            end
        end
        sink_quiet = 1'b0;
        drain();

        $display("faces sent %0d (%0d out of range), triangles checked %0d",
                 faces_sent, faces_ignored, tris_seen);
        $display("depths exercised: 0=%0d 1=%0d 2=%0d 3=%0d, mismatches %0d",
                 depth_used[0], depth_used[1], depth_used[2], depth_used[3], error_count);
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
